// File: sv/ucs2u16_pkg.sv
`default_nettype none

package ucs2u16_pkg;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_END   = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_ILLEGAL    = 2'd1,
    KIND_INCOMPLETE = 2'd2,
    KIND_UNUSED     = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IN_UTF32          = 3'd0,
    REG_IN_DEFAULT_LITTLE = 3'd1,
    REG_IN_DETECT_BOM     = 3'd2,
    REG_OUT_UTF16         = 3'd3,
    REG_OUT_LITTLE        = 3'd4,
    REG_OUT_EMIT_BOM      = 3'd5,
    REG_ILLEGAL_ACTION    = 3'd6,
    REG_NONIDENT_ACTION   = 3'd7
  } reg_index_t;

  // Actions for illegal or incomplete characters.
  localparam logic [1:0] ACT_REPORT  = 2'd0;
  localparam logic [1:0] ACT_DISCARD = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;

  // Code point constants.
  localparam logic [31:0] CP_NONCHAR_FFFE = 32'h0000_FFFE;
  localparam logic [31:0] CP_NONCHAR_FFFF = 32'h0000_FFFF;
  localparam logic [31:0] CP_UTF32_MAX    = 32'h0010_FFFF;
  localparam logic [31:0] CP_SURR_LOW     = 32'h0000_D800;
  localparam logic [31:0] CP_SURR_HIGH    = 32'h0000_DFFF;
  localparam logic [31:0] CP_BMP_MAX      = 32'h0000_FFFF;
  localparam logic [31:0] BOM_WORD_BIG    = 32'h0000_FEFF;
  localparam logic [31:0] BOM_WORD_LITTLE = 32'hFFFE_0000;
  localparam logic [15:0] UNIT_BOM        = 16'hFEFF;
  localparam logic [15:0] UNIT_REPL       = 16'hFFFD;
  localparam logic [5:0]  SURR_HI_TAG     = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG     = 6'b110111;
  localparam logic [19:0] SUPP_OFFSET     = 20'h1_0000;

  // Most result items one input item can cause.
  localparam int unsigned MAX_RES = 6;
  localparam int unsigned MAX_UNITS = 3;

endpackage : ucs2u16_pkg

`default_nettype wire

// File: sv/ucs4_to_utf16_stream_converter.sv
// The result bytes of a character are presented in the cycle after its fourth byte is accepted.
// Throughput: one input item per cycle while no results are pending; a character then
// gives up to six result items, sent one per cycle from the result buffer while out_stall is low.
// The input side is held while results are pending, except at the edge where the final one leaves.
// Reset (rst_n low, synchronous) restores configuration defaults and the start state.
`default_nettype none

module ucs4_to_utf16_stream_converter import ucs2u16_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_byte,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_replaced,
  output logic            out_last,
  // Configuration channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [1:0] cfg_data
);

  localparam int unsigned CntW = $clog2(MAX_RES + 1);

  // Configuration registers
  logic       cfg_in_utf32_r, cfg_in_default_little_r, cfg_in_detect_bom_r;
  logic       cfg_out_utf16_r, cfg_out_little_r, cfg_out_emit_bom_r;
  logic [1:0] cfg_illegal_action_r;
  logic       cfg_nonident_action_r;

  // Conversion state
  logic [23:0] gathered_r, gathered_nxt;
  logic [1:0]  byte_cnt_r, byte_cnt_nxt;
  logic        in_little_now_r, in_little_now_nxt;
  logic        in_bom_checked_r, in_bom_checked_nxt;
  logic        out_bom_done_r, out_bom_done_nxt;

  // Result buffer, entry 0 is presented at the output
  logic [7:0]    res_byte_r [MAX_RES];
  logic [1:0]    res_kind_r [MAX_RES];
  logic          res_repl_r [MAX_RES];
  logic [CntW-1:0] res_cnt_r;

  logic [7:0]    res_byte_nxt [MAX_RES];
  logic [1:0]    res_kind_nxt [MAX_RES];
  logic          res_repl_nxt [MAX_RES];
  logic [CntW-1:0] res_cnt_nxt;

  logic in_take, out_take;

  assign cfg_ready = 1'b1;

  // Output side is driven straight from the head of the buffer.
  assign out_valid    = (res_cnt_r != '0);
  assign out_byte     = res_byte_r[0];
  assign out_kind     = res_kind_r[0];
  assign out_replaced = res_repl_r[0];
  assign out_last     = (res_cnt_r == CntW'(1));
  assign out_take     = out_valid && !out_stall;

  // A new item is taken once the buffer is empty or its final item leaves now.
  assign in_stall = !((res_cnt_r == '0) || (out_last && !out_stall));
  assign in_take  = in_valid && !in_stall;

  // Character processing
  logic [31:0] word, word_swapped, cp;
  logic        word_done, bom_hit;
  logic        cp_illegal, cp_unrep;
  logic        do_bad, do_repl, do_char;
  logic [1:0]  bad_kind;
  logic [19:0] supp;
  logic [15:0] units [MAX_UNITS];
  logic        unit_repl [MAX_UNITS];
  logic [1:0]  n_units;
  logic        emit_err;

  assign word         = {gathered_r, in_byte};
  assign word_swapped = {word[7:0], word[15:8], word[23:16], word[31:24]};
  assign word_done    = (opcode_t'(in_opcode) == OP_DATA) && (byte_cnt_r == 2'd3);
  assign bom_hit      = !in_bom_checked_r &&
                        ((word == BOM_WORD_BIG) || (word == BOM_WORD_LITTLE));
  assign cp           = in_little_now_r ? word_swapped : word;
  assign supp         = cp[19:0] - SUPP_OFFSET;

  assign cp_illegal = (cp == CP_NONCHAR_FFFE) || (cp == CP_NONCHAR_FFFF) ||
                      (cfg_in_utf32_r ? (cp > CP_UTF32_MAX) : cp[31]) ||
                      ((cp >= CP_SURR_LOW) && (cp <= CP_SURR_HIGH));
  assign cp_unrep   = cfg_out_utf16_r ? (cp > CP_UTF32_MAX) : (cp > CP_BMP_MAX);

  // Decide what the item causes and update the conversion state.
  always_comb begin
    logic char_bad;
    logic [1:0] k;
    char_bad           = 1'b0;
    k                  = 2'd0;
    gathered_nxt       = gathered_r;
    byte_cnt_nxt       = byte_cnt_r;
    in_little_now_nxt  = in_little_now_r;
    in_bom_checked_nxt = in_bom_checked_r;
    out_bom_done_nxt   = out_bom_done_r;
    do_bad             = 1'b0;
    do_repl            = 1'b0;
    do_char            = 1'b0;
    bad_kind           = KIND_ILLEGAL;
    emit_err           = 1'b0;
    n_units            = 2'd0;
    for (int i = 0; i < MAX_UNITS; i++) begin
      units[i]     = '0;
      unit_repl[i] = 1'b0;
    end

    case (opcode_t'(in_opcode))
      OP_DATA: begin
        if (!word_done) begin
          gathered_nxt = {gathered_r[15:0], in_byte};
          byte_cnt_nxt = byte_cnt_r + 2'd1;
        end else begin
          gathered_nxt       = '0;
          byte_cnt_nxt       = '0;
          in_bom_checked_nxt = 1'b1;
          if (bom_hit) begin
            in_little_now_nxt = (word == BOM_WORD_LITTLE);
          end else if (cp_illegal) begin
            char_bad = 1'b1;
          end else if (cp_unrep) begin
            do_repl = !cfg_nonident_action_r;
          end else begin
            do_char = 1'b1;
          end
        end
      end
      OP_END: begin
        if (byte_cnt_r != 2'd0) begin
          gathered_nxt = '0;
          byte_cnt_nxt = '0;
          char_bad     = 1'b1;
          bad_kind     = KIND_INCOMPLETE;
        end
      end
      OP_RESET: begin
        gathered_nxt       = '0;
        byte_cnt_nxt       = '0;
        in_little_now_nxt  = cfg_in_default_little_r;
        in_bom_checked_nxt = !cfg_in_detect_bom_r;
        out_bom_done_nxt   = !cfg_out_emit_bom_r;
      end
      default: begin
      end
    endcase

    // Illegal or incomplete characters follow the configured action.
    if (char_bad) begin
      case (cfg_illegal_action_r)
        ACT_DISCARD: do_bad = 1'b0;
        ACT_REPLACE: do_repl = 1'b1;
        default:     do_bad = 1'b1;
      endcase
    end
    emit_err = do_bad;

    // Gather the 16-bit units: optional mark, then the character or its replacement.
    if ((do_repl || do_char) && !out_bom_done_r) begin
      units[0]         = UNIT_BOM;
      k                = 2'd1;
      out_bom_done_nxt = 1'b1;
    end
    if (do_repl) begin
      units[k]     = UNIT_REPL;
      unit_repl[k] = 1'b1;
      k            = k + 2'd1;
    end else if (do_char) begin
      if (cp > CP_BMP_MAX) begin
        units[k]     = {SURR_HI_TAG, supp[19:10]};
        units[k + 1] = {SURR_LO_TAG, supp[9:0]};
        k            = k + 2'd2;
      end else begin
        units[k] = cp[15:0];
        k        = k + 2'd1;
      end
    end
    n_units = k;
  end

  // Lay the units out as bytes, or a single error item.
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_byte_nxt[i] = res_byte_r[i];
      res_kind_nxt[i] = res_kind_r[i];
      res_repl_nxt[i] = res_repl_r[i];
    end
    res_cnt_nxt = res_cnt_r;

    if (in_take) begin
      for (int u = 0; u < MAX_UNITS; u++) begin
        res_byte_nxt[2*u]     = cfg_out_little_r ? units[u][7:0] : units[u][15:8];
        res_byte_nxt[2*u + 1] = cfg_out_little_r ? units[u][15:8] : units[u][7:0];
        res_kind_nxt[2*u]     = KIND_DATA;
        res_kind_nxt[2*u + 1] = KIND_DATA;
        res_repl_nxt[2*u]     = unit_repl[u];
        res_repl_nxt[2*u + 1] = unit_repl[u];
      end
      if (emit_err) begin
        res_byte_nxt[0] = '0;
        res_kind_nxt[0] = bad_kind;
        res_repl_nxt[0] = 1'b0;
        res_cnt_nxt     = CntW'(1);
      end else begin
        res_cnt_nxt = CntW'({n_units, 1'b0});
      end
    end else if (out_take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_byte_nxt[i] = res_byte_r[i + 1];
        res_kind_nxt[i] = res_kind_r[i + 1];
        res_repl_nxt[i] = res_repl_r[i + 1];
      end
      res_cnt_nxt = res_cnt_r - CntW'(1);
    end
  end

  // Configuration and conversion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_utf32_r          <= 1'b1;
      cfg_in_default_little_r <= 1'b0;
      cfg_in_detect_bom_r     <= 1'b1;
      cfg_out_utf16_r         <= 1'b1;
      cfg_out_little_r        <= 1'b0;
      cfg_out_emit_bom_r      <= 1'b1;
      cfg_illegal_action_r    <= ACT_REPORT;
      cfg_nonident_action_r   <= 1'b0;
      gathered_r              <= '0;
      byte_cnt_r              <= '0;
      in_little_now_r         <= 1'b0;
      in_bom_checked_r        <= 1'b0;
      out_bom_done_r          <= 1'b0;
      res_cnt_r               <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_IN_UTF32:          cfg_in_utf32_r          <= cfg_data[0];
          REG_IN_DEFAULT_LITTLE: cfg_in_default_little_r <= cfg_data[0];
          REG_IN_DETECT_BOM:     cfg_in_detect_bom_r     <= cfg_data[0];
          REG_OUT_UTF16:         cfg_out_utf16_r         <= cfg_data[0];
          REG_OUT_LITTLE:        cfg_out_little_r        <= cfg_data[0];
          REG_OUT_EMIT_BOM:      cfg_out_emit_bom_r      <= cfg_data[0];
          REG_ILLEGAL_ACTION:    cfg_illegal_action_r    <= cfg_data;
          REG_NONIDENT_ACTION:   cfg_nonident_action_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_take) begin
        gathered_r       <= gathered_nxt;
        byte_cnt_r       <= byte_cnt_nxt;
        in_little_now_r  <= in_little_now_nxt;
        in_bom_checked_r <= in_bom_checked_nxt;
        out_bom_done_r   <= out_bom_done_nxt;
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_byte_r[i] <= res_byte_nxt[i];
      res_kind_r[i] <= res_kind_nxt[i];
      res_repl_r[i] <= res_repl_nxt[i];
    end
  end

  // The buffer never holds more items than one input item can cause.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= CntW'(MAX_RES))
    else $error("result buffer count out of range");

  // An item is taken only when the pending results are gone or leaving.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (res_cnt_r == '0) || (res_cnt_r == CntW'(1) && !out_stall))
    else $error("item accepted over pending results");

  // The first three bytes of a word cause no result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (opcode_t'(in_opcode) == OP_DATA) && (byte_cnt_r != 2'd3) |=> !out_valid)
    else $error("result after a partial word");

  // An error item stands alone, carries no byte and closes its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind_t'(out_kind) != KIND_DATA) |->
      (out_byte == 8'd0) && !out_replaced && out_last)
    else $error("malformed error item");

endmodule : ucs4_to_utf16_stream_converter

`default_nettype wire
